/* design/clcd_pkg.sv */
package clcd_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_INIT   = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_LOAD   = 3'd4
  } cmd_e;

  localparam logic [1:0] REG_INIT_FIRST  = 2'd0;
  localparam logic [1:0] REG_INIT_SECOND = 2'd1;
  localparam logic [1:0] REG_CLEAR       = 2'd2;
  localparam logic [1:0] REG_NEWLINE     = 2'd3;

  localparam logic [7:0] RST_INIT_FIRST  = 8'd56;
  localparam logic [7:0] RST_INIT_SECOND = 8'd12;
  localparam logic [7:0] RST_CLEAR       = 8'd1;
  localparam logic [7:0] RST_NEWLINE     = 8'd192;

  typedef struct packed {
    logic [7:0] init_first;
    logic [7:0] init_second;
    logic [7:0] clear;
    logic [7:0] newline;
  } cfg_t;

  typedef struct packed {
    logic       load_bus;
    logic       from_store;
    logic [7:0] cmd_byte;
    logic       rs;
    logic       en;
    logic       idle;
  } pin_upd_t;

endpackage

/* design/clcd_regs.sv */
module clcd_regs
  import clcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_first  <= RST_INIT_FIRST;
      cfg_q.init_second <= RST_INIT_SECOND;
      cfg_q.clear       <= RST_CLEAR;
      cfg_q.newline     <= RST_NEWLINE;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_INIT_FIRST:  cfg_q.init_first  <= pwdata[7:0];
        REG_INIT_SECOND: cfg_q.init_second <= pwdata[7:0];
        REG_CLEAR:       cfg_q.clear       <= pwdata[7:0];
        REG_NEWLINE:     cfg_q.newline     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INIT_FIRST:  prdata = {{(PDATA_W-8){1'b0}}, cfg_q.init_first};
      REG_INIT_SECOND: prdata = {{(PDATA_W-8){1'b0}}, cfg_q.init_second};
      REG_CLEAR:       prdata = {{(PDATA_W-8){1'b0}}, cfg_q.clear};
      REG_NEWLINE:     prdata = {{(PDATA_W-8){1'b0}}, cfg_q.newline};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/clcd_store.sv */
module clcd_store
  import clcd_pkg::*;
#(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/clcd_ctrl.sv */
module clcd_ctrl
  import clcd_pkg::*;
#(
  parameter int unsigned CHARS_PER_ROW = 16,
  parameter int unsigned STORE_SIZE    = 32,
  parameter int unsigned ADDR_W        = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [2:0]        command_i,
  input  logic [ADDR_W-1:0] char_address_i,
  input  cfg_t              cfg_i,
  output pin_upd_t          upd_o,
  output logic              we_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o
);

  localparam int unsigned BL_W = $clog2(STORE_SIZE + 2);
  localparam int unsigned RL_W = $clog2(CHARS_PER_ROW + 1);
  localparam logic [BL_W-1:0]   UPD_BYTES = BL_W'(STORE_SIZE + 1);
  localparam logic [RL_W-1:0]   ROW_FULL  = RL_W'(CHARS_PER_ROW);
  localparam logic [ADDR_W-1:0] PTR_LAST  = ADDR_W'(STORE_SIZE - 1);
  localparam logic [ADDR_W-1:0] PTR_ONE   = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] PTR_CLEAR = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] PTR_END   = ADDR_W'(3);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WCMD  = 3'd1,
    PH_WDATA = 3'd2,
    PH_EN_HI = 3'd3,
    PH_EN_LO = 3'd4,
    PH_WAIT  = 3'd5
  } phase_e;

  phase_e            phase_q, phase_d;
  phase_e            ret_q, ret_d;
  logic [BL_W-1:0]   bytes_q, bytes_d;
  logic [RL_W-1:0]   row_q, row_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              wait_q, wait_d;
  logic              rs_q, rs_d;
  logic              en_q, en_d;
  logic              load_bus, from_store;
  logic [7:0]        cmd_byte;

  always_comb begin
    phase_d    = phase_q;
    ret_d      = ret_q;
    bytes_d    = bytes_q;
    row_d      = row_q;
    ptr_d      = ptr_q;
    wait_d     = wait_q;
    rs_d       = rs_q;
    en_d       = en_q;
    load_bus   = 1'b0;
    from_store = 1'b0;
    cmd_byte   = cfg_i.clear;
    we_o       = 1'b0;
    if (ptr_q == '0) begin
      cmd_byte = cfg_i.init_first;
    end else if (ptr_q == PTR_ONE) begin
      cmd_byte = cfg_i.init_second;
    end
    case (command_i)
      CMD_TICK: begin
        case (phase_q)
          PH_WCMD: begin
            if (bytes_q != '0) begin
              bytes_d  = bytes_q - BL_W'(1);
              rs_d     = 1'b0;
              load_bus = 1'b1;
              if (ptr_q < PTR_END) begin
                ptr_d = ptr_q + PTR_ONE;
              end
              phase_d = PH_EN_HI;
              ret_d   = PH_WAIT;
              wait_d  = 1'b1;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_WDATA: begin
            if (bytes_q != '0) begin
              bytes_d = bytes_q - BL_W'(1);
              if (row_q != '0) begin
                row_d      = row_q - RL_W'(1);
                rs_d       = 1'b1;
                from_store = 1'b1;
                ptr_d      = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_ONE;
              end else begin
                row_d    = ROW_FULL;
                rs_d     = 1'b0;
                load_bus = 1'b1;
                cmd_byte = cfg_i.newline;
              end
              phase_d = PH_EN_HI;
              ret_d   = PH_WDATA;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_EN_HI: begin
            en_d    = 1'b1;
            phase_d = PH_EN_LO;
          end
          PH_EN_LO: begin
            en_d    = 1'b0;
            phase_d = ret_q;
          end
          PH_WAIT: begin
            if (!wait_q) begin
              phase_d = PH_WCMD;
            end else begin
              wait_d = 1'b0;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      CMD_INIT: begin
        bytes_d = BL_W'(3);
        ptr_d   = '0;
        phase_d = PH_WCMD;
      end
      CMD_UPDATE: begin
        if (phase_q == PH_IDLE) begin
          ptr_d   = '0;
          bytes_d = UPD_BYTES;
          row_d   = ROW_FULL;
          phase_d = PH_WDATA;
        end
      end
      CMD_CLEAR: begin
        bytes_d = BL_W'(1);
        ptr_d   = PTR_CLEAR;
        phase_d = PH_WCMD;
      end
      CMD_LOAD: begin
        we_o = fire_i && ({1'b0, char_address_i} < (ADDR_W + 1)'(STORE_SIZE));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ret_q   <= PH_IDLE;
      bytes_q <= '0;
      row_q   <= '0;
      ptr_q   <= '0;
      wait_q  <= 1'b0;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      ret_q   <= ret_d;
      bytes_q <= bytes_d;
      row_q   <= row_d;
      ptr_q   <= ptr_d;
      wait_q  <= wait_d;
      rs_q    <= rs_d;
      en_q    <= en_d;
    end
  end

  assign re_o    = fire_i & from_store;
  assign raddr_o = ptr_q;

  always_comb begin
    upd_o.load_bus   = load_bus;
    upd_o.from_store = from_store;
    upd_o.cmd_byte   = cmd_byte;
    upd_o.rs         = rs_d;
    upd_o.en         = en_d;
    upd_o.idle       = (phase_d == PH_IDLE);
  end

endmodule

/* design/clcd_out.sv */
module clcd_out
  import clcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  output logic       ready_o,
  input  pin_upd_t   upd_i,
  input  logic [7:0] rdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] bus_byte_o,
  output logic       reg_select_o,
  output logic       enable_line_o,
  output logic       is_idle_o
);

  logic       s1_valid_q, s1_valid_d;
  pin_upd_t   s1_upd_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] bus_q, bus_d;
  logic       rs_q, en_q, idle_q;
  logic       s1_move;

  assign s1_move = s1_valid_q & (~out_valid_q | out_ready_i);
  assign ready_o = ~s1_valid_q | s1_move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fire_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    bus_d = bus_q;
    if (s1_upd_q.from_store) begin
      bus_d = rdata_i;
    end else if (s1_upd_q.load_bus) begin
      bus_d = s1_upd_q.cmd_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bus_q       <= '0;
      rs_q        <= 1'b0;
      en_q        <= 1'b0;
      idle_q      <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        bus_q  <= bus_d;
        rs_q   <= s1_upd_q.rs;
        en_q   <= s1_upd_q.en;
        idle_q <= s1_upd_q.idle;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_upd_q <= upd_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bus_byte_o    = bus_q;
  assign reg_select_o  = rs_q;
  assign enable_line_o = en_q;
  assign is_idle_o     = idle_q;

endmodule

/* design/char_lcd_write_sequencer_top.sv */
// Pin sequencer for an 8-bit parallel character display of two rows.
// Each input transaction carries a command: a tick moves the pin machine one
// step, init and clear restart the command byte sequence, update starts a
// full screen refresh when the machine is idle, and load char writes one
// character into the screen memory. Every input transaction produces exactly
// one output transaction with the bus byte, RS, EN and the idle flag as they
// stand after that command.
// After its input transaction is accepted, a result passes through the phase
// machine and screen memory read stage, then the output register. One
// transaction can be accepted in every cycle while the receiver takes results.
// When the receiver stalls, the pipeline fills its two stages and then input
// ready drops until the output transaction is taken; nothing is lost.
// Reset clears the phase machine and pins to idle and zero and restores the
// command byte registers. The screen memory is not cleared and must be
// loaded before an update. The user must write command bytes over the APB
// port only while no transaction is in flight; the block does not enforce it.
module char_lcd_write_sequencer_top
  import clcd_pkg::*;
#(
  parameter int unsigned CHARS_PER_ROW = 16,
  parameter int unsigned ROW_COUNT     = 2
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [2:0]                               command_i,
  input  logic [$clog2(ROW_COUNT*CHARS_PER_ROW)-1:0] char_address_i,
  input  logic [7:0]                               char_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [7:0]                               bus_byte_o,
  output logic                                     reg_select_o,
  output logic                                     enable_line_o,
  output logic                                     is_idle_o,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [PADDR_W-1:0]                       paddr,
  input  logic [PDATA_W-1:0]                       pwdata,
  output logic [PDATA_W-1:0]                       prdata,
  output logic                                     pready
);

  localparam int unsigned STORE_SIZE = ROW_COUNT * CHARS_PER_ROW;
  localparam int unsigned ADDR_W     = $clog2(STORE_SIZE);

  cfg_t              cfg;
  pin_upd_t          upd;
  logic              fire;
  logic              we, re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign pready = 1'b1;
  assign fire   = in_valid_i & in_ready_o;

  clcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  clcd_ctrl #(
    .CHARS_PER_ROW (CHARS_PER_ROW),
    .STORE_SIZE    (STORE_SIZE),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .command_i      (command_i),
    .char_address_i (char_address_i),
    .cfg_i          (cfg),
    .upd_o          (upd),
    .we_o           (we),
    .re_o           (re),
    .raddr_o        (raddr)
  );

  clcd_store #(
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (char_address_i),
    .wdata_i (char_value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  clcd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .ready_o       (in_ready_o),
    .upd_i         (upd),
    .rdata_i       (rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bus_byte_o    (bus_byte_o),
    .reg_select_o  (reg_select_o),
    .enable_line_o (enable_line_o),
    .is_idle_o     (is_idle_o)
  );

endmodule
